// File: rtl/core/cplx_atan_pkg.sv
// Shared constants, stage payload type and arctangent table for the atan2 pipeline.
package cplx_atan_pkg;

    localparam int DATA_WIDTH  = 16;                          // width of real_part / imag_part
    localparam int STAGES      = 16;                          // CORDIC iterations, 8..32
    localparam int FRAC_BITS   = 16;                          // extra fraction bits on x, y and z
    localparam int XY_W        = DATA_WIDTH + FRAC_BITS + 3;  // headroom: fold, sqrt2, gain
    localparam int Z_W         = 33;                          // angle accumulator, pi = 2^31
    localparam int ANG_W       = 17;                          // output angle width
    localparam int SUM_W       = ANG_W + 2;                   // angle sum before range wrap
    localparam int TAB_IDX_W   = 5;                           // table has 32 entries

    localparam logic signed [ANG_W-1:0] ANG_ZERO    = ANG_W'(0);
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = ANG_W'(16384);
    localparam logic signed [ANG_W-1:0] ANG_PI      = ANG_W'(32768);
    localparam logic signed [SUM_W-1:0] SUM_PI      = SUM_W'(32768);
    localparam logic signed [SUM_W-1:0] SUM_TWO_PI  = SUM_W'(65536);
    localparam logic signed [Z_W-1:0]   Z_RND_HALF  = Z_W'(1 << (FRAC_BITS - 1));

    // Payload handed from one pipeline stage to the next.
    typedef struct packed {
        logic                    bypass;  // axis point: angle is offset alone
        logic signed [ANG_W-1:0] offset;  // base angle added after the iterations
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [Z_W-1:0]   z;
    } stage_t;

    // atan(2^-i) * 2^31 / pi, rounded to nearest.
    function automatic logic signed [Z_W-1:0] atan_tab(input logic [TAB_IDX_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:    v = Z_W'(536870912);
            5'd1:    v = Z_W'(316933406);
            5'd2:    v = Z_W'(167458907);
            5'd3:    v = Z_W'(85004756);
            5'd4:    v = Z_W'(42667331);
            5'd5:    v = Z_W'(21354465);
            5'd6:    v = Z_W'(10679838);
            5'd7:    v = Z_W'(5340245);
            5'd8:    v = Z_W'(2670163);
            5'd9:    v = Z_W'(1335087);
            5'd10:   v = Z_W'(667544);
            5'd11:   v = Z_W'(333772);
            5'd12:   v = Z_W'(166886);
            5'd13:   v = Z_W'(83443);
            5'd14:   v = Z_W'(41722);
            5'd15:   v = Z_W'(20861);
            5'd16:   v = Z_W'(10430);
            5'd17:   v = Z_W'(5215);
            5'd18:   v = Z_W'(2608);
            5'd19:   v = Z_W'(1304);
            5'd20:   v = Z_W'(652);
            5'd21:   v = Z_W'(326);
            5'd22:   v = Z_W'(163);
            5'd23:   v = Z_W'(81);
            5'd24:   v = Z_W'(41);
            5'd25:   v = Z_W'(20);
            5'd26:   v = Z_W'(10);
            5'd27:   v = Z_W'(5);
            5'd28:   v = Z_W'(3);
            5'd29:   v = Z_W'(1);
            5'd30:   v = Z_W'(1);
            default: v = Z_W'(0);
        endcase
        return v;
    endfunction

endpackage

// File: rtl/core/cplx_atan_prep.sv
// Front stage: axis decode, fold into the right half plane, scale to fixed point.
module cplx_atan_prep
    import cplx_atan_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic signed [DATA_WIDTH-1:0] real_part,
    input  logic signed [DATA_WIDTH-1:0] imag_part,
    output logic                         out_valid,
    output stage_t                       out_data
);

    logic   valid_reg;
    stage_t data_reg;
    stage_t data_next;

    always_comb
    begin
        logic signed [XY_W-1:0] xs;
        logic signed [XY_W-1:0] ys;
        xs = XY_W'(real_part) <<< FRAC_BITS;
        ys = XY_W'(imag_part) <<< FRAC_BITS;

        data_next.bypass = 1'b0;
        data_next.offset = ANG_ZERO;
        data_next.x      = xs;
        data_next.y      = ys;
        data_next.z      = '0;

        if (real_part == '0)
        begin
            data_next.bypass = 1'b1;
            if (imag_part == '0)
                data_next.offset = ANG_ZERO;
            else if (imag_part[DATA_WIDTH-1])
                data_next.offset = -ANG_HALF_PI;
            else
                data_next.offset = ANG_HALF_PI;
        end
        else if (imag_part == '0)
        begin
            data_next.bypass = 1'b1;
            data_next.offset = real_part[DATA_WIDTH-1] ? ANG_PI : ANG_ZERO;
        end
        else if (real_part[DATA_WIDTH-1])
        begin
            // left half plane: rotate by pi, base angle keeps the sign of y
            data_next.x      = -xs;
            data_next.y      = -ys;
            data_next.offset = imag_part[DATA_WIDTH-1] ? -ANG_PI : ANG_PI;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: rtl/core/cplx_atan_cell.sv
// One CORDIC vectoring iteration with its pipeline register.
module cplx_atan_cell
    import cplx_atan_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic [TAB_IDX_W-1:0] stage,
    input  logic                 in_valid,
    input  stage_t               in_data,
    output logic                 out_valid,
    output stage_t               out_data
);

    logic   valid_reg;
    stage_t data_reg;
    stage_t data_next;

    always_comb
    begin
        logic signed [XY_W-1:0] xs;
        logic signed [XY_W-1:0] ys;
        logic signed [Z_W-1:0]  da;
        xs = in_data.x >>> stage;
        ys = in_data.y >>> stage;
        da = atan_tab(stage);

        data_next = in_data;
        if (!in_data.y[XY_W-1])
        begin
            // y >= 0: rotate clockwise
            data_next.x = in_data.x + ys;
            data_next.y = in_data.y - xs;
            data_next.z = in_data.z + da;
        end
        else
        begin
            data_next.x = in_data.x - ys;
            data_next.y = in_data.y + xs;
            data_next.z = in_data.z - da;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: rtl/core/cplx_atan_out.sv
// Back stage: round the accumulated angle, add base, wrap to range, output register.
module cplx_atan_out
    import cplx_atan_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    range_mode,
    input  logic                    in_valid,
    input  stage_t                  in_data,
    output logic                    out_valid,
    output logic signed [ANG_W-1:0] angle
);

    logic                    valid_reg;
    logic signed [ANG_W-1:0] angle_reg;
    logic signed [ANG_W-1:0] angle_next;

    always_comb
    begin
        logic signed [Z_W-1:0]   zr;
        logic signed [SUM_W-1:0] sum;
        zr  = (in_data.z + Z_RND_HALF) >>> FRAC_BITS;
        sum = SUM_W'(in_data.offset);
        if (!in_data.bypass)
            sum = sum + SUM_W'(zr);
        if (sum <= -SUM_PI)
            sum = sum + SUM_TWO_PI;
        if (sum > SUM_PI)
            sum = sum - SUM_TWO_PI;
        if (range_mode && sum[SUM_W-1])
            sum = sum + SUM_TWO_PI;
        angle_next = ANG_W'(sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            angle_reg <= angle_next;
    end

    assign out_valid = valid_reg;
    assign angle     = angle_reg;

endmodule

// File: rtl/core/complex_argument_atan2_top.sv
// Top level of the pipelined CORDIC atan2 unit with its range-mode register.
//
// Returns the argument of real_part + j*imag_part in binary angle units
// (pi = 32768). range_mode 0 gives (-pi, pi], 1 gives [0, 2pi); the negative
// real axis reads as +pi in both. Axis points are decoded exactly; all others
// are folded into the right half plane and resolved by STAGES CORDIC cells in a
// row, one iteration per cell. Throughput is one beat per clock unless stalled
// by out_ready; registered in decode stage, cells, output register. The whole
// row moves together: it advances whenever the output register is empty or its
// beat is being taken, so in_ready follows out_ready while the output is full.
// range_mode is read at the output stage, so only change it with the pipe empty.
module complex_argument_atan2_top
    import cplx_atan_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    // config channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_data,
    // input beats
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [DATA_WIDTH-1:0] real_part,
    input  logic signed [DATA_WIDTH-1:0] imag_part,
    // result beats
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [ANG_W-1:0]      angle
);

    logic   range_mode_reg;
    logic   adv;                 // whole row shifts by one this cycle
    logic   vld [STAGES+1];      // valid of prep stage and each cell
    stage_t dat [STAGES+1];

    // config register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            range_mode_reg <= 1'b0;
        else if (cfg_valid)
            range_mode_reg <= cfg_data;
    end

    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    cplx_atan_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (in_valid),
        .real_part (real_part),
        .imag_part (imag_part),
        .out_valid (vld[0]),
        .out_data  (dat[0])
    );

    // row of CORDIC cells, cell i shifts by i
    for (genvar i = 0; i < STAGES; i++)
    begin : g_cell
        cplx_atan_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .stage     (TAB_IDX_W'(i)),
            .in_valid  (vld[i]),
            .in_data   (dat[i]),
            .out_valid (vld[i+1]),
            .out_data  (dat[i+1])
        );
    end

    cplx_atan_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .range_mode (range_mode_reg),
        .in_valid   (vld[STAGES]),
        .in_data    (dat[STAGES]),
        .out_valid  (out_valid),
        .angle      (angle)
    );

endmodule
